// ===== sv/mdpwm_pkg.sv =====
// Shared types, constants and helper functions for the menu-driven PWM motor controller.
`default_nettype none

package mdpwm_pkg;

  localparam int unsigned ADC_BITS = 12;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned TPP_W    = 16;
  localparam int unsigned COUNT_W  = PCT_W + TPP_W;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef enum logic [1:0] {
    MODE_DIR  = 2'd0,
    MODE_CTRL = 2'd1,
    MODE_TERM = 2'd2,
    MODE_POT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_PCT = 2'd0,
    CFG_POT_THRESHOLD = 2'd1
  } cfg_idx_t;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  localparam logic [7:0] KEY_0 = 8'h30;
  localparam logic [7:0] KEY_1 = 8'h31;
  localparam logic [7:0] KEY_2 = 8'h32;
  localparam logic [7:0] KEY_6 = 8'h36;
  localparam logic [7:0] KEY_H = 8'h68;
  localparam logic [7:0] KEY_A = 8'h61;

  typedef struct packed {
    logic [1:0]          operation;
    logic [7:0]          key_code;
    logic [ADC_BITS-1:0] adc_sample;
  } in_req_t;

  typedef struct packed {
    logic             drive_cw;
    logic             drive_ccw;
    logic [PCT_W-1:0] speed_percent;
    logic [1:0]       rotation_dir;
    logic [1:0]       mode_now;
    logic             status_changed;
  } out_req_t;

  // sample*100 >> ADC_BITS, always below 100
  function automatic logic [PCT_W-1:0] pot_speed(input logic [ADC_BITS-1:0] v);
    logic [ADC_BITS+PCT_W-1:0] prod;
    prod = (ADC_BITS+PCT_W)'(v) * (ADC_BITS+PCT_W)'(PCT_FULL);
    return prod[ADC_BITS+PCT_W-1:ADC_BITS];
  endfunction

  function automatic logic [PCT_W-1:0] key_speed(input logic [2:0] k);
    logic [PCT_W-1:0] s;
    case (k)
      3'd0: s = 7'd0;
      3'd1: s = 7'd50;
      3'd2: s = 7'd60;
      3'd3: s = 7'd70;
      3'd4: s = 7'd80;
      3'd5: s = 7'd90;
      3'd6: s = 7'd100;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/menu_driven_pwm_motor_controller_core.sv =====
// Top level: menu state, PWM countdown and registered result of the motor controller.
// The result is registered: it appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the result register is the only stage, and a new
// request is taken whenever that register is empty or being drained in the same cycle.
// Per request the slowest path is one 7x16 multiply of a percentage by ticks_per_percent.
// Reset (synchronous, rst_n low): menu back to direction choice, motor stopped, all
// speeds and counts zero, registers back to 800 ticks per percent and threshold 20.
`default_nettype none

module menu_driven_pwm_motor_controller_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire mdpwm_pkg::in_req_t                  in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      mdpwm_pkg::out_req_t                 out_data,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [mdpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mdpwm_pkg::CFG_W-1:0]         cfg_data
);

  mdpwm_pkg::mode_t                  mode_r, mode_nxt;
  logic [1:0]                        dir_r, dir_nxt;
  logic                              level_r, level_nxt;
  logic [mdpwm_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic [mdpwm_pkg::PCT_W-1:0]       duty_r, duty_nxt;
  logic [mdpwm_pkg::ADC_BITS-1:0]    pot_r, pot_nxt;
  logic [mdpwm_pkg::TPP_W-1:0]       tpp_r;
  logic [mdpwm_pkg::ADC_BITS-1:0]    thresh_r;
  logic                              out_valid_r;
  mdpwm_pkg::out_req_t               out_data_r, out_data_nxt;

  logic                              in_acc;
  logic                              running;
  logic [mdpwm_pkg::PCT_W-1:0]       mul_pct;
  logic [mdpwm_pkg::PCT_W-1:0]       tick_pct;
  logic                              tick_level;
  logic [mdpwm_pkg::COUNT_W-1:0]     reload;
  logic [mdpwm_pkg::ADC_BITS-1:0]    diff;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign running   = (mode_r == mdpwm_pkg::MODE_TERM) || (mode_r == mdpwm_pkg::MODE_POT);

  // level and reload percentage at countdown expiry
  always_comb begin
    if (duty_r == '0) begin
      tick_level = 1'b0;
      tick_pct   = mdpwm_pkg::PCT_FULL;
    end else if (duty_r >= mdpwm_pkg::PCT_FULL) begin
      tick_level = 1'b1;
      tick_pct   = mdpwm_pkg::PCT_FULL;
    end else if (!level_r) begin
      tick_level = 1'b1;
      tick_pct   = duty_r;
    end else begin
      tick_level = 1'b0;
      tick_pct   = mdpwm_pkg::PCT_FULL - duty_r;
    end
    // a motor start (key request) always reloads the full period
    mul_pct = (in_data.operation == mdpwm_pkg::OP_KEY) ? mdpwm_pkg::PCT_FULL : tick_pct;
    reload  = mdpwm_pkg::COUNT_W'(mul_pct) * mdpwm_pkg::COUNT_W'(tpp_r);
    diff    = (in_data.adc_sample >= pot_r) ? in_data.adc_sample - pot_r
                                            : pot_r - in_data.adc_sample;
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    dir_nxt   = dir_r;
    level_nxt = level_r;
    count_nxt = count_r;
    duty_nxt  = duty_r;
    pot_nxt   = pot_r;
    case (in_data.operation)
      mdpwm_pkg::OP_KEY: begin
        case (mode_r)
          mdpwm_pkg::MODE_DIR: begin
            if (in_data.key_code == mdpwm_pkg::KEY_1) begin
              dir_nxt  = mdpwm_pkg::DIR_CW;
              mode_nxt = mdpwm_pkg::MODE_CTRL;
            end else if (in_data.key_code == mdpwm_pkg::KEY_2) begin
              dir_nxt  = mdpwm_pkg::DIR_CCW;
              mode_nxt = mdpwm_pkg::MODE_CTRL;
            end
          end
          mdpwm_pkg::MODE_CTRL: begin
            if (in_data.key_code == mdpwm_pkg::KEY_1) begin
              mode_nxt  = mdpwm_pkg::MODE_TERM;
              level_nxt = 1'b0;
              count_nxt = reload;
            end else if (in_data.key_code == mdpwm_pkg::KEY_2) begin
              mode_nxt  = mdpwm_pkg::MODE_POT;
              duty_nxt  = mdpwm_pkg::pot_speed(pot_r);
              level_nxt = 1'b0;
              count_nxt = reload;
            end
          end
          default: begin
            if (in_data.key_code == mdpwm_pkg::KEY_H) begin
              dir_nxt = mdpwm_pkg::DIR_CW;
            end else if (in_data.key_code == mdpwm_pkg::KEY_A) begin
              dir_nxt = mdpwm_pkg::DIR_CCW;
            end else if (mode_r == mdpwm_pkg::MODE_TERM &&
                         in_data.key_code >= mdpwm_pkg::KEY_0 &&
                         in_data.key_code <= mdpwm_pkg::KEY_6) begin
              duty_nxt = mdpwm_pkg::key_speed(in_data.key_code[2:0]);
            end
          end
        endcase
      end
      mdpwm_pkg::OP_SAMPLE: begin
        if (mode_r == mdpwm_pkg::MODE_POT && diff >= thresh_r) begin
          pot_nxt  = in_data.adc_sample;
          duty_nxt = mdpwm_pkg::pot_speed(in_data.adc_sample);
        end
      end
      mdpwm_pkg::OP_TICK: begin
        if (running) begin
          if (count_r > mdpwm_pkg::COUNT_W'(1)) begin
            count_nxt = count_r - mdpwm_pkg::COUNT_W'(1);
          end else begin
            level_nxt = tick_level;
            count_nxt = reload;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    out_data_nxt.drive_cw       = (dir_nxt == mdpwm_pkg::DIR_CW) ? level_nxt : 1'b0;
    out_data_nxt.drive_ccw      = (dir_nxt != mdpwm_pkg::DIR_CW) ? level_nxt : 1'b0;
    out_data_nxt.speed_percent  = duty_nxt;
    out_data_nxt.rotation_dir   = dir_nxt;
    out_data_nxt.mode_now       = mode_nxt;
    out_data_nxt.status_changed = (duty_nxt != duty_r) || (dir_nxt != dir_r) ||
                                  (mode_nxt != mode_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= mdpwm_pkg::MODE_DIR;
      dir_r       <= mdpwm_pkg::DIR_NONE;
      level_r     <= 1'b0;
      count_r     <= '0;
      duty_r      <= '0;
      pot_r       <= '0;
      tpp_r       <= 16'd800;
      thresh_r    <= 12'd20;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r  <= mode_nxt;
        dir_r   <= dir_nxt;
        level_r <= level_nxt;
        count_r <= count_nxt;
        duty_r  <= duty_nxt;
        pot_r   <= pot_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mdpwm_pkg::CFG_TICKS_PER_PCT: tpp_r    <= cfg_data;
          mdpwm_pkg::CFG_POT_THRESHOLD: thresh_r <= cfg_data[mdpwm_pkg::ADC_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.drive_cw && out_data_r.drive_ccw))
    else $error("both drive outputs high");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r <= mdpwm_pkg::PCT_FULL)
    else $error("duty above 100 percent");

  a_dir_chosen: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != mdpwm_pkg::MODE_DIR |-> dir_r != mdpwm_pkg::DIR_NONE)
    else $error("menu past direction choice without a direction");

  a_run_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    running |=> running)
    else $error("left run mode");

  a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
    !running |-> !level_r)
    else $error("pwm level high while motor stopped");
`endif

endmodule

`default_nettype wire
